// ===== rtl/multitouch_event_synthesizer_unit_assert.svh =====
// assertion macros for the multitouch event synthesizer top level
// expects signals named clk and rst in the including module
`ifndef MULTITOUCH_EVENT_SYNTHESIZER_UNIT_ASSERT_SVH
`define MULTITOUCH_EVENT_SYNTHESIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define MES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mes_pkg.sv =====
// shared types, codes and constants of the multitouch event synthesizer
// no dependencies
package mes_pkg;

  localparam int MAX_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REQ_COMMIT = 3'd0;
  localparam logic [2:0] REQ_RESET  = 3'd1;
  localparam logic [2:0] REQ_DOWN   = 3'd2;
  localparam logic [2:0] REQ_MOVE   = 3'd3;
  localparam logic [2:0] REQ_UP     = 3'd4;

  localparam logic [3:0]  CFG_LIMIT_RESET  = 4'd8;
  localparam logic [31:0] TOUCH_MAJOR_VAL  = 32'd6;
  localparam logic [31:0] WIDTH_MAJOR_VAL  = 32'd4;
  localparam logic [31:0] TRACKING_RELEASE = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_SLOT_PROTOCOL,
    CFG_SEND_TRACKING_ID,
    CFG_SEND_BUTTON_TOUCH,
    CFG_SEND_TOUCH_MAJOR,
    CFG_SEND_WIDTH_MAJOR,
    CFG_SEND_PRESSURE,
    CFG_CONTACTS_IN_USE
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_COMMIT,
    OP_RESET,
    OP_DOWN,
    OP_MOVE,
    OP_UP,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    EV_SLOT,
    EV_TRACKING_ID,
    EV_BUTTON,
    EV_TOUCH_MAJOR,
    EV_WIDTH_MAJOR,
    EV_PRESSURE,
    EV_POS_X,
    EV_POS_Y,
    EV_MT_REPORT,
    EV_SYNC
  } ev_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DOWN,
    PH_MOVED,
    PH_UP
  } ph_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RESET,
    ST_WALK,
    ST_ADV,
    ST_SLOT,
    ST_TID,
    ST_BTN,
    ST_MAJOR,
    ST_WIDTH,
    ST_PRESS,
    ST_X,
    ST_Y,
    ST_REPORT,
    ST_SYNC,
    ST_DOWN
  } eng_state_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  idx;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] p;
  } cmd_t;

  typedef struct packed {
    logic       proto_b;
    logic       tid;
    logic       btn;
    logic       major;
    logic       width;
    logic       press;
    logic [3:0] limit;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/multitouch_event_synthesizer_unit.sv =====
// top level of the multitouch event synthesizer: config registers, front, engine
// depends on mes_pkg, mes_front, mes_engine and the assertion macro header
//
//   channel  | dir | transfer on               | payload
//   s_axis   | in  | s_axis_tvalid & tready    | tuser req_type, tdata contact and position
//   m_axis   | out | m_axis_tvalid & tready    | tuser event_kind, tdata value, tlast
//   cfg      | in  | cfg_valid & cfg_ready     | cfg_index register, cfg_data value
//
// a command is taken from the queue and decoded, then stepped through its event sequence;
// a protocol a commit walks every slot below the limit and sequences the live ones,
// with the sequencer stepping one event kind a cycle while the output register is free.
// a two-entry command queue keeps accepting while the sequencer or the output stalls, until it is full.
// reset clears slot phases, counters and queue; config is always ready.
`include "multitouch_event_synthesizer_unit_assert.svh"

module multitouch_event_synthesizer_unit import mes_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // contact_index, pos_x, pos_y, touch_pressure
  input  logic [2:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // event_value
  output logic [3:0]  m_axis_tuser,   // event_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  cfg_t      cfg;
  q_status_t q_stat;
  cmd_t      q_cmd;
  logic      q_pop;
  ev_t       ev_kind;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.proto_b <= 1'b0;
      cfg.tid     <= 1'b0;
      cfg.btn     <= 1'b0;
      cfg.major   <= 1'b0;
      cfg.width   <= 1'b0;
      cfg.press   <= 1'b0;
      cfg.limit   <= CFG_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOT_PROTOCOL:     cfg.proto_b <= cfg_data[0];
        CFG_SEND_TRACKING_ID:  cfg.tid     <= cfg_data[0];
        CFG_SEND_BUTTON_TOUCH: cfg.btn     <= cfg_data[0];
        CFG_SEND_TOUCH_MAJOR:  cfg.major   <= cfg_data[0];
        CFG_SEND_WIDTH_MAJOR:  cfg.width   <= cfg_data[0];
        CFG_SEND_PRESSURE:     cfg.press   <= cfg_data[0];
        CFG_CONTACTS_IN_USE:   cfg.limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  mes_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .q_stat   (q_stat),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  mes_engine #(
    .MaxSlots (MAX_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .ev_valid (m_axis_tvalid),
    .ev_ready (m_axis_tready),
    .ev_kind  (ev_kind),
    .ev_value (m_axis_tdata),
    .ev_last  (m_axis_tlast)
  );

  assign m_axis_tuser = ev_kind;

  `MES_ASSERT_NEXT(a_push_queued, s_axis_tvalid && s_axis_tready, q_stat.valid, "accepted command not queued")
  `MES_ASSERT_IMP(a_full_stalls, q_stat.full, !s_axis_tready, "ready while queue full")
  `MES_ASSERT_IMP(a_report_not_last, m_axis_tvalid && m_axis_tuser == EV_MT_REPORT, !m_axis_tlast, "mt report marked last")
  `MES_ASSERT_IMP(a_sync_zero, m_axis_tvalid && m_axis_tuser == EV_SYNC, m_axis_tdata == 32'd0, "sync report with nonzero value")

endmodule

// ===== rtl/mes_front.sv =====
// front end: accepts touch commands, classifies the request and queues them
// depends on mes_pkg
module mes_front import mes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // contact_index, pos_x, pos_y, touch_pressure
  input  logic [2:0]  s_tuser,   // req_type
  output q_status_t   q_stat,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  localparam int QPtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCntW-1:0] QFull = QCntW'(QUEUE_DEPTH);
  localparam logic [QPtrW-1:0] QLast = QPtrW'(QUEUE_DEPTH - 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  cmd_t             in_cmd;
  logic             push;

  always_comb begin
    in_cmd.idx = s_tdata[3:0];
    in_cmd.x   = s_tdata[19:4];
    in_cmd.y   = s_tdata[35:20];
    in_cmd.p   = s_tdata[51:36];
    case (s_tuser)
      REQ_COMMIT: in_cmd.op = OP_COMMIT;
      REQ_RESET:  in_cmd.op = OP_RESET;
      REQ_DOWN:   in_cmd.op = OP_DOWN;
      REQ_MOVE:   in_cmd.op = OP_MOVE;
      REQ_UP:     in_cmd.op = OP_UP;
      default:    in_cmd.op = OP_NOP;
    endcase
  end

  assign s_tready     = (count != QFull);
  assign push         = s_tvalid && s_tready;
  assign q_stat.valid = (count != '0);
  assign q_stat.full  = (count == QFull);
  assign q_cmd        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QLast) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mes_engine.sv =====
// back end: slot state, commit walk and event sequencer with output register
// depends on mes_pkg
module mes_engine import mes_pkg::*; #(
  parameter int MaxSlots = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  q_status_t   q_stat,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        ev_valid,
  input  logic        ev_ready,
  output ev_t         ev_kind,
  output logic [31:0] ev_value,
  output logic        ev_last
);

  localparam int IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam logic [3:0] MaxLim = 4'(MaxSlots);

  eng_state_t      state, state_next;
  cmd_t            cmd, cmd_next;
  logic [IdxW-1:0] ptr, ptr_next;
  ph_t             phase [MaxSlots];
  ph_t             phase_next [MaxSlots];
  logic [15:0]     slot_x [MaxSlots];
  logic [15:0]     slot_y [MaxSlots];
  logic [15:0]     slot_pressure [MaxSlots];
  logic [7:0]      active_count, active_count_next;
  logic [30:0]     id_counter, id_counter_next;
  logic            found, found_next;
  logic            pending_down, pending_down_next;
  logic            walking, walking_next;
  logic            up_seq, up_seq_next;
  logic            tid_en, tid_en_next;
  logic            btn_en, btn_en_next;
  logic            btn_val, btn_val_next;
  logic [31:0]     tid_val, tid_val_next;

  logic [3:0]  lim;
  logic        ok;
  ph_t         cur_ph;
  logic        out_free;
  logic        ptr_last;
  logic [7:0]  count_inc;
  logic [7:0]  count_dec;
  logic [30:0] id_inc;
  logic        store_en;
  logic        emit_en;
  ev_t         emit_kind;
  logic [31:0] emit_value;
  logic        emit_last;

  assign lim       = (cfg.limit < MaxLim) ? cfg.limit : MaxLim;
  assign ok        = (cmd.idx < lim);
  assign cur_ph    = phase[ptr];
  assign out_free  = !ev_valid || ev_ready;
  assign ptr_last  = ((4'(ptr) + 4'd1) >= lim);
  assign count_inc = (active_count == 8'hFF) ? active_count : active_count + 8'd1;
  assign count_dec = (active_count == 8'h00) ? active_count : active_count - 8'd1;
  assign id_inc    = (id_counter == 31'h7FFF_FFFF) ? '0 : id_counter + 31'd1;

  always_comb begin
    logic       live_seen;
    logic [7:0] c_after;
    state_next        = state;
    cmd_next          = cmd;
    ptr_next          = ptr;
    phase_next        = phase;
    active_count_next = active_count;
    id_counter_next   = id_counter;
    found_next        = found;
    pending_down_next = pending_down;
    walking_next      = walking;
    up_seq_next       = up_seq;
    tid_en_next       = tid_en;
    btn_en_next       = btn_en;
    btn_val_next      = btn_val;
    tid_val_next      = tid_val;
    q_pop             = 1'b0;
    store_en          = 1'b0;
    emit_en           = 1'b0;
    emit_kind         = EV_SYNC;
    emit_value        = '0;
    emit_last         = 1'b0;
    live_seen         = 1'b0;
    c_after           = active_count;
    case (state)
      ST_IDLE: begin
        if (q_stat.valid) begin
          q_pop             = 1'b1;
          cmd_next          = q_cmd;
          ptr_next          = q_cmd.idx[IdxW-1:0];
          pending_down_next = 1'b0;
          found_next        = 1'b0;
          walking_next      = 1'b0;
          state_next        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        case (cmd.op)
          OP_COMMIT: begin
            if (cfg.proto_b) begin
              state_next = ST_SYNC;
            end else begin
              ptr_next     = '0;
              walking_next = 1'b1;
              found_next   = 1'b0;
              state_next   = ST_WALK;
            end
          end
          OP_RESET: state_next = ST_RESET;
          OP_DOWN: begin
            if (ok) begin
              pending_down_next = 1'b1;
              state_next = (cur_ph != PH_IDLE) ? ST_RESET : ST_DOWN;
            end
          end
          OP_MOVE: begin
            if (ok && cur_ph != PH_IDLE) begin
              store_en = 1'b1;
              if (cfg.proto_b) begin
                tid_en_next  = 1'b0;
                btn_en_next  = 1'b0;
                up_seq_next  = 1'b0;
                walking_next = 1'b0;
                state_next   = ST_SLOT;
              end else begin
                phase_next[ptr] = PH_MOVED;
              end
            end
          end
          OP_UP: begin
            if (ok && cur_ph != PH_IDLE) begin
              if (cfg.proto_b) begin
                phase_next[ptr]   = PH_IDLE;
                active_count_next = count_dec;
                tid_val_next      = TRACKING_RELEASE;
                tid_en_next       = 1'b1;
                btn_en_next       = cfg.btn && (count_dec == 8'd0);
                btn_val_next      = 1'b0;
                up_seq_next       = 1'b1;
                walking_next      = 1'b0;
                state_next        = ST_SLOT;
              end else begin
                phase_next[ptr] = PH_UP;
              end
            end
          end
          default: ;
        endcase
      end
      ST_RESET: begin
        if (cfg.proto_b) begin
          for (int s = 0; s < MaxSlots; s++) begin
            if ((4'(s) < lim) && (phase[s] != PH_IDLE)) begin
              phase_next[s] = PH_IDLE;
              live_seen     = 1'b1;
            end
          end
          ptr_next = cmd.idx[IdxW-1:0];
          if (live_seen) begin
            state_next = ST_SYNC;
          end else if (pending_down) begin
            state_next = ST_DOWN;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          for (int s = 0; s < MaxSlots; s++) begin
            if ((4'(s) < lim) && (phase[s] == PH_DOWN || phase[s] == PH_MOVED)) begin
              phase_next[s] = PH_UP;
            end
          end
          ptr_next     = '0;
          walking_next = 1'b1;
          found_next   = 1'b0;
          state_next   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (lim == 4'd0) begin
          state_next = ST_ADV;
        end else begin
          case (cur_ph)
            PH_DOWN, PH_MOVED: begin
              c_after           = (cur_ph == PH_DOWN) ? count_inc : active_count;
              found_next        = 1'b1;
              active_count_next = c_after;
              tid_val_next      = {{(32-IdxW){1'b0}}, ptr};
              tid_en_next       = cfg.tid;
              btn_en_next       = cfg.btn && (cur_ph == PH_DOWN) && (c_after == 8'd1);
              btn_val_next      = 1'b1;
              up_seq_next       = 1'b0;
              phase_next[ptr]   = PH_MOVED;
              state_next        = ST_TID;
            end
            PH_UP: begin
              found_next        = 1'b1;
              active_count_next = count_dec;
              tid_val_next      = {{(32-IdxW){1'b0}}, ptr};
              tid_en_next       = cfg.tid;
              btn_en_next       = cfg.btn && (count_dec == 8'd0);
              btn_val_next      = 1'b0;
              up_seq_next       = 1'b1;
              phase_next[ptr]   = PH_IDLE;
              state_next        = ST_TID;
            end
            default: state_next = ST_ADV;
          endcase
        end
      end
      ST_ADV: begin
        if (ptr_last) begin
          ptr_next     = cmd.idx[IdxW-1:0];
          walking_next = 1'b0;
          if (found) begin
            state_next = ST_SYNC;
          end else if (pending_down) begin
            state_next = ST_DOWN;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          ptr_next   = ptr + 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_SLOT: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_SLOT;
          emit_value = {28'd0, cmd.idx};
          state_next = ST_TID;
        end
      end
      ST_TID: begin
        if (!tid_en) begin
          state_next = ST_BTN;
        end else if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_TRACKING_ID;
          emit_value = tid_val;
          emit_last  = !walking && up_seq && !btn_en;
          state_next = ST_BTN;
        end
      end
      ST_BTN: begin
        if (!btn_en || out_free) begin
          if (btn_en) begin
            emit_en    = 1'b1;
            emit_kind  = EV_BUTTON;
            emit_value = {31'd0, btn_val};
            emit_last  = !walking && up_seq;
          end
          if (!up_seq) begin
            state_next = ST_MAJOR;
          end else begin
            state_next = walking ? ST_REPORT : ST_IDLE;
          end
        end
      end
      ST_MAJOR: begin
        if (!cfg.major) begin
          state_next = ST_WIDTH;
        end else if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_TOUCH_MAJOR;
          emit_value = TOUCH_MAJOR_VAL;
          state_next = ST_WIDTH;
        end
      end
      ST_WIDTH: begin
        if (!cfg.width) begin
          state_next = ST_PRESS;
        end else if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_WIDTH_MAJOR;
          emit_value = WIDTH_MAJOR_VAL;
          state_next = ST_PRESS;
        end
      end
      ST_PRESS: begin
        if (!cfg.press) begin
          state_next = ST_X;
        end else if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_PRESSURE;
          emit_value = {16'd0, slot_pressure[ptr]};
          state_next = ST_X;
        end
      end
      ST_X: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_POS_X;
          emit_value = {16'd0, slot_x[ptr]};
          state_next = ST_Y;
        end
      end
      ST_Y: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_POS_Y;
          emit_value = {16'd0, slot_y[ptr]};
          emit_last  = !walking;
          state_next = walking ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_MT_REPORT;
          state_next = ST_ADV;
        end
      end
      ST_SYNC: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_kind  = EV_SYNC;
          emit_last  = !(pending_down && cfg.proto_b);
          state_next = pending_down ? ST_DOWN : ST_IDLE;
        end
      end
      ST_DOWN: begin
        phase_next[ptr] = PH_DOWN;
        store_en        = 1'b1;
        if (cfg.proto_b) begin
          id_counter_next   = id_inc;
          active_count_next = count_inc;
          tid_val_next      = {1'b0, id_inc};
          tid_en_next       = 1'b1;
          btn_en_next       = cfg.btn && (count_inc == 8'd1);
          btn_val_next      = 1'b1;
          up_seq_next       = 1'b0;
          walking_next      = 1'b0;
          state_next        = ST_SLOT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ptr          <= '0;
      active_count <= '0;
      id_counter   <= '0;
      found        <= 1'b0;
      pending_down <= 1'b0;
      walking      <= 1'b0;
      up_seq       <= 1'b0;
      tid_en       <= 1'b0;
      btn_en       <= 1'b0;
      ev_valid     <= 1'b0;
      for (int s = 0; s < MaxSlots; s++) begin
        phase[s] <= PH_IDLE;
      end
    end else begin
      state        <= state_next;
      ptr          <= ptr_next;
      phase        <= phase_next;
      active_count <= active_count_next;
      id_counter   <= id_counter_next;
      found        <= found_next;
      pending_down <= pending_down_next;
      walking      <= walking_next;
      up_seq       <= up_seq_next;
      tid_en       <= tid_en_next;
      btn_en       <= btn_en_next;
      if (emit_en) begin
        ev_valid <= 1'b1;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    btn_val <= btn_val_next;
    tid_val <= tid_val_next;
    if (store_en) begin
      slot_x[ptr]        <= cmd.x;
      slot_y[ptr]        <= cmd.y;
      slot_pressure[ptr] <= cmd.p;
    end
    if (emit_en) begin
      ev_kind  <= emit_kind;
      ev_value <= emit_value;
      ev_last  <= emit_last;
    end
  end

endmodule

// ===== sim/tb_multitouch_event_synthesizer_unit.sv =====
// testbench for the multitouch event synthesizer: directed and random touch commands,
// events predicted in both protocols and compared field by field with the output stream
// depends on mes_pkg and multitouch_event_synthesizer_unit
module tb_multitouch_event_synthesizer_unit;
  import mes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_EVENTS    = 58;
  localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
  localparam logic [30:0] TRACK_ID_MAX  = 31'h7FFF_FFFF;
  localparam int          DRAIN_CYCLES  = 200;

  typedef struct {
    ev_t         kind;
    logic [31:0] value;
    logic        last;
  } touch_event_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;

  touch_event_t expected_events[$];
  touch_event_t cmd_events[$];
  int           fail_count;
  bit           stall_on;

  // predicted block state
  ph_t         touch_phase[MAX_SLOTS_DEF];
  logic [15:0] touch_x[MAX_SLOTS_DEF];
  logic [15:0] touch_y[MAX_SLOTS_DEF];
  logic [15:0] touch_p[MAX_SLOTS_DEF];
  logic [7:0]  live_count;
  logic [30:0] track_id;
  logic        mode_b, tid_en, btn_en, major_en, width_en, press_en;
  logic [3:0]  slot_cap;

  multitouch_event_synthesizer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_touch_state();
    for (int s = 0; s < MAX_SLOTS_DEF; s++) begin
      touch_phase[s] = PH_IDLE;
      touch_x[s] = '0;
      touch_y[s] = '0;
      touch_p[s] = '0;
    end
    live_count = '0;
    track_id = '0;
    mode_b = 1'b0;
    tid_en = 1'b0;
    btn_en = 1'b0;
    major_en = 1'b0;
    width_en = 1'b0;
    press_en = 1'b0;
    slot_cap = CFG_LIMIT_RESET;
  endfunction

  function automatic int unsigned accepted_slots();
    return (slot_cap < MAX_SLOTS_DEF) ? slot_cap : MAX_SLOTS_DEF;
  endfunction

  function automatic void push_event(ev_t kind, logic [31:0] value);
    if (cmd_events.size() < MAX_EVENTS) cmd_events.push_back('{kind, value, 1'b0});
  endfunction

  function automatic void count_up();
    if (live_count != 8'hFF) live_count++;
  endfunction

  function automatic void count_down();
    if (live_count != 8'h00) live_count--;
  endfunction

  function automatic void contact_body(logic [15:0] p, logic [15:0] x, logic [15:0] y);
    if (major_en) push_event(EV_TOUCH_MAJOR, TOUCH_MAJOR_VAL);
    if (width_en) push_event(EV_WIDTH_MAJOR, WIDTH_MAJOR_VAL);
    if (press_en) push_event(EV_PRESSURE, {16'd0, p});
    push_event(EV_POS_X, {16'd0, x});
    push_event(EV_POS_Y, {16'd0, y});
  endfunction

  function automatic void commit_anonymous();
    int unsigned lim;
    bit found;
    ph_t ph;
    lim = accepted_slots();
    found = 1'b0;
    for (int unsigned s = 0; s < lim; s++) begin
      ph = touch_phase[s];
      if (ph == PH_DOWN || ph == PH_MOVED) begin
        found = 1'b1;
        if (ph == PH_DOWN) count_up();
        if (tid_en) push_event(EV_TRACKING_ID, 32'(s));
        if (ph == PH_DOWN && live_count == 8'd1 && btn_en) push_event(EV_BUTTON, 32'd1);
        contact_body(touch_p[s], touch_x[s], touch_y[s]);
        push_event(EV_MT_REPORT, 32'd0);
        touch_phase[s] = PH_MOVED;
      end else if (ph == PH_UP) begin
        found = 1'b1;
        count_down();
        if (tid_en) push_event(EV_TRACKING_ID, 32'(s));
        if (live_count == 8'd0 && btn_en) push_event(EV_BUTTON, 32'd0);
        push_event(EV_MT_REPORT, 32'd0);
        touch_phase[s] = PH_IDLE;
      end
    end
    if (found) push_event(EV_SYNC, 32'd0);
  endfunction

  function automatic void reset_touches();
    int unsigned lim;
    bit found;
    lim = accepted_slots();
    found = 1'b0;
    for (int unsigned s = 0; s < lim; s++) begin
      if (mode_b) begin
        if (touch_phase[s] != PH_IDLE) begin
          touch_phase[s] = PH_IDLE;
          found = 1'b1;
        end
      end else if (touch_phase[s] == PH_DOWN || touch_phase[s] == PH_MOVED) begin
        touch_phase[s] = PH_UP;
      end
    end
    if (mode_b) begin
      if (found) push_event(EV_SYNC, 32'd0);
    end else begin
      commit_anonymous();
    end
  endfunction

  function automatic void predict_events(logic [2:0] req, logic [3:0] idx,
                                         logic [15:0] x, logic [15:0] y, logic [15:0] p);
    bit ok;
    ok = idx < accepted_slots();
    cmd_events.delete();
    if (req == REQ_COMMIT) begin
      if (mode_b) push_event(EV_SYNC, 32'd0);
      else commit_anonymous();
    end else if (req == REQ_RESET) begin
      reset_touches();
    end else if (req == REQ_DOWN && ok) begin
      if (touch_phase[idx] != PH_IDLE) reset_touches();
      touch_phase[idx] = PH_DOWN;
      touch_x[idx] = x;
      touch_y[idx] = y;
      touch_p[idx] = p;
      if (mode_b) begin
        track_id = (track_id != TRACK_ID_MAX) ? track_id + 31'd1 : '0;
        count_up();
        push_event(EV_SLOT, 32'(idx));
        push_event(EV_TRACKING_ID, {1'b0, track_id});
        if (live_count == 8'd1 && btn_en) push_event(EV_BUTTON, 32'd1);
        contact_body(p, x, y);
      end
    end else if (req == REQ_MOVE && ok && touch_phase[idx] != PH_IDLE) begin
      touch_x[idx] = x;
      touch_y[idx] = y;
      touch_p[idx] = p;
      if (mode_b) begin
        push_event(EV_SLOT, 32'(idx));
        contact_body(p, x, y);
      end else begin
        touch_phase[idx] = PH_MOVED;
      end
    end else if (req == REQ_UP && ok && touch_phase[idx] != PH_IDLE) begin
      if (mode_b) begin
        touch_phase[idx] = PH_IDLE;
        count_down();
        push_event(EV_SLOT, 32'(idx));
        push_event(EV_TRACKING_ID, TRACKING_RELEASE);
        if (live_count == 8'd0 && btn_en) push_event(EV_BUTTON, 32'd0);
      end else begin
        touch_phase[idx] = PH_UP;
      end
    end
    if (cmd_events.size() > 0) cmd_events[cmd_events.size() - 1].last = 1'b1;
    foreach (cmd_events[i]) expected_events.push_back(cmd_events[i]);
  endfunction

  function automatic logic [15:0] random_coord();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // output checker
  always @(posedge clk) begin : check_events
    touch_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d value %0d last %0b", $time,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: event kind expected %0d actual %0d", $time, want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== want.value) begin
          $display("%0t: event value expected %0d actual %0d", $time,
                   $signed(want.value), $signed(m_axis_tdata));
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last flag expected %0b actual %0b", $time, want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_on) begin
        case ($urandom_range(0, 15))
          0, 1: begin
            m_axis_tready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
            m_axis_tready = 1'b1;
          end
          2: repeat ($urandom_range(20, 60)) @(negedge clk);
          default: ;
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL multitouch_event_synthesizer_unit");
    $finish;
  end

  task automatic send_touch_cmd(logic [2:0] req, logic [3:0] idx,
                                logic [15:0] x, logic [15:0] y, logic [15:0] p);
    @(negedge clk);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {4'd0, p, y, x, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_events(req, idx, x, y, p);
  endtask

  // hold the sender until every expected event has come out, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [3:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SLOT_PROTOCOL:     mode_b = value[0];
      CFG_SEND_TRACKING_ID:  tid_en = value[0];
      CFG_SEND_BUTTON_TOUCH: btn_en = value[0];
      CFG_SEND_TOUCH_MAJOR:  major_en = value[0];
      CFG_SEND_WIDTH_MAJOR:  width_en = value[0];
      CFG_SEND_PRESSURE:     press_en = value[0];
      CFG_CONTACTS_IN_USE:   slot_cap = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(bit proto, bit tid, bit btn, bit major, bit width, bit press,
                               logic [3:0] limit);
    wait_idle();
    write_reg(CFG_SLOT_PROTOCOL, {3'd0, proto});
    write_reg(CFG_SEND_TRACKING_ID, {3'd0, tid});
    write_reg(CFG_SEND_BUTTON_TOUCH, {3'd0, btn});
    write_reg(CFG_SEND_TOUCH_MAJOR, {3'd0, major});
    write_reg(CFG_SEND_WIDTH_MAJOR, {3'd0, width});
    write_reg(CFG_SEND_PRESSURE, {3'd0, press});
    write_reg(CFG_CONTACTS_IN_USE, limit);
  endtask

  task automatic test_anonymous_report();
    apply_setting(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd8);
    send_touch_cmd(REQ_DOWN, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    for (int s = 1; s < 7; s++)
      send_touch_cmd(REQ_DOWN, 4'(s), random_coord(), random_coord(), random_coord());
    send_touch_cmd(REQ_DOWN, 4'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // all eight contacts with every option on: the longest report
    send_touch_cmd(REQ_COMMIT, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_MOVE, 4'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_touch_cmd(REQ_UP, 4'd7, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_COMMIT, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    // down on a live slot releases everything first
    send_touch_cmd(REQ_DOWN, 4'd3, 16'h1234, 16'hABCD, 16'h8001);
    send_touch_cmd(REQ_COMMIT, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_ignored_requests();
    send_touch_cmd(REQ_MOVE, 4'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_touch_cmd(REQ_UP, 4'd2, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_DOWN, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_touch_cmd(REQ_UNUSED_LO, 4'd1, 16'h5555, 16'hAAAA, 16'h5555);
    send_touch_cmd(REQ_UNUSED_HI, 4'd15, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_touch_cmd(REQ_RESET, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_COMMIT, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_slotted_report();
    apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd8);
    send_touch_cmd(REQ_DOWN, 4'd1, 16'h0001, 16'hFFFE, 16'h7FFF);
    send_touch_cmd(REQ_MOVE, 4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_touch_cmd(REQ_DOWN, 4'd1, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_UP, 4'd1, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_COMMIT, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_DOWN, 4'd2, 16'h8000, 16'h0800, 16'h0080);
    send_touch_cmd(REQ_RESET, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_touch_cmd(REQ_RESET, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic send_random_command();
    logic [2:0] req;
    logic [3:0] idx;
    int unsigned r, lim;
    int live[$];
    lim = accepted_slots();
    for (int s = 0; s < lim; s++)
      if (touch_phase[s] != PH_IDLE) live.push_back(s);
    r = $urandom_range(0, 99);
    if (r < 4) req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    else if (r < 14) req = REQ_COMMIT;
    else if (r < 18) req = REQ_RESET;
    else if (r < 40) req = REQ_DOWN;
    else if (r < 75) req = REQ_MOVE;
    else if (r < 90) req = REQ_UP;
    else req = REQ_COMMIT;
    idx = 4'($urandom_range(0, 15));
    if ((req == REQ_MOVE || req == REQ_UP) && live.size() > 0 && $urandom_range(0, 9) < 8)
      idx = 4'(live[$urandom_range(0, live.size() - 1)]);
    else if (req == REQ_DOWN && lim > 0 && $urandom_range(0, 9) < 8)
      idx = 4'($urandom_range(0, lim - 1));
    send_touch_cmd(req, idx, random_coord(), random_coord(), random_coord());
  endtask

  task automatic test_random_sessions();
    bit          protos[8] = '{0, 1, 0, 1, 1, 0, 1, 0};
    logic [3:0]  limits[8] = '{8, 1, 15, 0, 3, 8, 6, 2};
    int unsigned lengths[8] = '{10, 8, 8, 4, 8, 8, 8, 6};
    bit          flag_on;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 2) begin
        flag_on = (ph == 0);
        apply_setting(protos[ph], flag_on, flag_on, flag_on, flag_on, flag_on, limits[ph]);
      end else begin
        apply_setting(protos[ph], 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom), limits[ph]);
      end
      repeat (lengths[ph]) send_random_command();
    end
  endtask

  // repeated downs never lower the contact count in slotted mode, so it climbs to its ceiling
  task automatic test_count_saturation();
    apply_setting(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd8);
    repeat (270)
      send_touch_cmd(REQ_DOWN, 4'($urandom_range(0, 7)), random_coord(), random_coord(),
                     random_coord());
    for (int s = 0; s < MAX_SLOTS_DEF; s++)
      if (touch_phase[s] != PH_IDLE)
        send_touch_cmd(REQ_UP, 4'(s), random_coord(), random_coord(), random_coord());
    send_touch_cmd(REQ_COMMIT, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_COMMIT;
    cfg_valid = 1'b0;
    cfg_index = CFG_SLOT_PROTOCOL;
    cfg_data = '0;
    fail_count = 0;
    stall_on = 1'b0;
    clear_touch_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    stall_on = 1'b1;
    test_anonymous_report();
    test_ignored_requests();
    test_slotted_report();
    test_random_sessions();
    stall_on = 1'b0;
    test_count_saturation();
    wait_idle();
    if (fail_count == 0) begin
      $display("PASS multitouch_event_synthesizer_unit");
    end else begin
      $display("FAIL multitouch_event_synthesizer_unit");
    end
    $finish;
  end

endmodule
